// File: rtl/gcc_pkg.sv
// Package: shared constants, types and helpers for the connected components block.
`timescale 1ns / 1ps

package gcc_pkg;

    localparam int MAX_NODES = 32;
    localparam int N_LIMIT   = (MAX_NODES < 32) ? MAX_NODES : 32;
    localparam int ROW_W     = N_LIMIT;
    localparam int IDX_W     = $clog2(N_LIMIT);
    localparam int CNT_W     = $clog2(N_LIMIT + 1);
    localparam int FIELD_W   = 5;
    localparam int CFG_W     = 6;

    localparam logic [CFG_W-1:0] NODE_COUNT_RESET = CFG_W'(32);
    localparam logic [CFG_W-1:0] NODE_LIMIT       = CFG_W'(N_LIMIT);

    localparam logic OP_ADD     = 1'b0;
    localparam logic OP_RESOLVE = 1'b1;

    typedef logic [ROW_W-1:0] row_t;

    typedef struct packed {
        logic             add;
        logic             clear;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
    } adj_cmd_t;

    function automatic row_t low_mask(input logic [CNT_W-1:0] n);
        row_t m;
        for (int k = 0; k < ROW_W; k++)
        begin
            m[k] = (CNT_W'(k) < n);
        end
        return m;
    endfunction

endpackage

// File: rtl/gcc_adj_matrix.sv
// Adjacency matrix: symmetric bit rows with edge set, full clear and one row read port.
`timescale 1ns / 1ps

module gcc_adj_matrix (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gcc_pkg::adj_cmd_t         cmd,
    input  logic [gcc_pkg::IDX_W-1:0] rd_addr,
    output gcc_pkg::row_t             rd_row
);

    gcc_pkg::row_t rows_reg  [gcc_pkg::N_LIMIT];
    gcc_pkg::row_t rows_next [gcc_pkg::N_LIMIT];

    always_comb
    begin
        for (int r = 0; r < gcc_pkg::N_LIMIT; r++)
        begin
            rows_next[r] = rows_reg[r];
        end
        if (cmd.clear)
        begin
            for (int r = 0; r < gcc_pkg::N_LIMIT; r++)
            begin
                rows_next[r] = '0;
            end
        end
        else if (cmd.add)
        begin
            rows_next[cmd.a][cmd.b] = 1'b1;
            rows_next[cmd.b][cmd.a] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < gcc_pkg::N_LIMIT; r++)
            begin
                rows_reg[r] <= '0;
            end
        end
        else
        begin
            for (int r = 0; r < gcc_pkg::N_LIMIT; r++)
            begin
                rows_reg[r] <= rows_next[r];
            end
        end
    end

    assign rd_row = rows_reg[rd_addr];

endmodule

// File: rtl/gcc_seq.sv
// Sequencer: edge loading, closure sweeps over one row per cycle, and component emission.
`timescale 1ns / 1ps

module gcc_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [gcc_pkg::CFG_W-1:0]   node_count_cfg,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        opcode,
    input  logic [gcc_pkg::FIELD_W-1:0] node_a,
    input  logic [gcc_pkg::FIELD_W-1:0] node_b,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [gcc_pkg::FIELD_W-1:0] component_index,
    output logic [gcc_pkg::FIELD_W-1:0] member_node,
    output logic                        last_in_component,
    output logic                        last,
    output gcc_pkg::adj_cmd_t           cmd,
    output logic [gcc_pkg::IDX_W-1:0]   rd_addr,
    input  gcc_pkg::row_t               rd_row
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEEK,
        ST_GROW,
        ST_EMIT,
        ST_CLEAR
    } state_t;

    state_t                        state_reg;
    logic [gcc_pkg::CNT_W-1:0]     n_reg;
    gcc_pkg::row_t                 mask_reg;
    logic [gcc_pkg::CNT_W-1:0]     i_reg;
    logic [gcc_pkg::CNT_W-1:0]     j_reg;
    gcc_pkg::row_t                 members_reg;
    gcc_pkg::row_t                 seen_reg;
    logic                          changed_reg;
    logic [gcc_pkg::FIELD_W-1:0]   comp_reg;
    logic                          out_valid_reg;
    logic [gcc_pkg::FIELD_W-1:0]   comp_out_reg;
    logic [gcc_pkg::FIELD_W-1:0]   member_out_reg;
    logic                          lic_out_reg;
    logic                          last_out_reg;

    logic [gcc_pkg::CNT_W-1:0]     eff_n;
    logic                          accept;
    logic                          j_end;
    logic                          j_member;
    gcc_pkg::row_t                 grown;
    gcc_pkg::row_t                 rest;
    logic                          out_free;
    logic [gcc_pkg::CNT_W-1:0]     j_inc;
    logic                          emit_word;

    assign eff_n = (node_count_cfg > gcc_pkg::NODE_LIMIT)
                   ? gcc_pkg::CNT_W'(gcc_pkg::N_LIMIT)
                   : node_count_cfg[gcc_pkg::CNT_W-1:0];

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign rd_addr   = j_reg[gcc_pkg::IDX_W-1:0];
    assign j_inc     = j_reg + gcc_pkg::CNT_W'(1);
    assign j_end     = (j_inc == n_reg);
    assign j_member  = members_reg[j_reg[gcc_pkg::IDX_W-1:0]];
    assign grown     = members_reg | (j_member ? (rd_row & mask_reg) : '0);
    assign rest      = members_reg & ~gcc_pkg::low_mask(j_inc);
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_word = (state_reg == ST_EMIT) && j_member && out_free;

    always_comb
    begin
        cmd.add   = accept && (opcode == gcc_pkg::OP_ADD)
                    && ({1'b0, node_a} < gcc_pkg::CNT_W'(eff_n))
                    && ({1'b0, node_b} < gcc_pkg::CNT_W'(eff_n));
        cmd.clear = (state_reg == ST_CLEAR);
        cmd.a     = node_a[gcc_pkg::IDX_W-1:0];
        cmd.b     = node_b[gcc_pkg::IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            n_reg          <= '0;
            mask_reg       <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            members_reg    <= '0;
            seen_reg       <= '0;
            changed_reg    <= 1'b0;
            comp_reg       <= '0;
            comp_out_reg   <= '0;
            member_out_reg <= '0;
            lic_out_reg    <= 1'b0;
            last_out_reg   <= 1'b0;
        end
        else
        begin
            if (emit_word)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (opcode == gcc_pkg::OP_RESOLVE))
                    begin
                        n_reg     <= eff_n;
                        mask_reg  <= gcc_pkg::low_mask(eff_n);
                        i_reg     <= '0;
                        seen_reg  <= '0;
                        comp_reg  <= '0;
                        state_reg <= ST_SEEK;
                    end
                end
                ST_SEEK:
                begin
                    if (i_reg == n_reg)
                    begin
                        state_reg <= ST_CLEAR;
                    end
                    else if (seen_reg[i_reg[gcc_pkg::IDX_W-1:0]])
                    begin
                        i_reg <= i_reg + gcc_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        members_reg <= gcc_pkg::row_t'(1) << i_reg[gcc_pkg::IDX_W-1:0];
                        j_reg       <= '0;
                        changed_reg <= 1'b0;
                        state_reg   <= ST_GROW;
                    end
                end
                ST_GROW:
                begin
                    members_reg <= grown;
                    if (j_end)
                    begin
                        j_reg       <= '0;
                        changed_reg <= 1'b0;
                        if (!changed_reg && (grown == members_reg))
                        begin
                            state_reg <= ST_EMIT;
                        end
                    end
                    else
                    begin
                        j_reg <= j_inc;
                        if (grown != members_reg)
                        begin
                            changed_reg <= 1'b1;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (!j_member || out_free)
                    begin
                        if (j_member)
                        begin
                            comp_out_reg   <= comp_reg;
                            member_out_reg <= j_reg[gcc_pkg::FIELD_W-1:0];
                            lic_out_reg    <= (rest == '0);
                            last_out_reg   <= (rest == '0)
                                              && ((seen_reg | members_reg) == mask_reg);
                        end
                        if (j_end)
                        begin
                            seen_reg  <= seen_reg | members_reg;
                            comp_reg  <= comp_reg + gcc_pkg::FIELD_W'(1);
                            i_reg     <= i_reg + gcc_pkg::CNT_W'(1);
                            state_reg <= ST_SEEK;
                        end
                        else
                        begin
                            j_reg <= j_inc;
                        end
                    end
                end
                ST_CLEAR:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid         = out_valid_reg;
    assign component_index   = comp_out_reg;
    assign member_node       = member_out_reg;
    assign last_in_component = lic_out_reg;
    assign last              = last_out_reg;

endmodule

// File: rtl/graph_connected_components.sv
// Top level: connected components of an undirected graph over up to 32 nodes.
//
// Input channel (in_valid / in_stall) carries one word per cycle while in_stall
// is low: opcode 0 adds the edge node_a - node_b, opcode 1 resolves. An edge word
// produces nothing; an edge naming a node at or above node_count is dropped.
// A resolve holds in_stall high while the sequencer works: for each component
// it sweeps the member rows of the adjacency matrix, one row read per cycle,
// until a full sweep adds no node, and then emits that component's members.
// Output channel (out_valid / out_stall) gives one word per node, components in
// order of their smallest node and members ascending, with last_in_component
// and last marking the ends. A stalled output word holds and emission waits.
// After emission the matrix is cleared and the block takes words
// again. The config channel (cfg_valid / cfg_ready) writes node_count.
// Reset clears the matrix, drops any output word and sets node_count to 32.
`timescale 1ns / 1ps

module graph_connected_components (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [gcc_pkg::CFG_W-1:0]   node_count,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        opcode,
    input  logic [gcc_pkg::FIELD_W-1:0] node_a,
    input  logic [gcc_pkg::FIELD_W-1:0] node_b,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [gcc_pkg::FIELD_W-1:0] component_index,
    output logic [gcc_pkg::FIELD_W-1:0] member_node,
    output logic                        last_in_component,
    output logic                        last
);

    logic [gcc_pkg::CFG_W-1:0] node_count_reg;
    gcc_pkg::adj_cmd_t         cmd;
    logic [gcc_pkg::IDX_W-1:0] rd_addr;
    gcc_pkg::row_t             rd_row;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= gcc_pkg::NODE_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            node_count_reg <= node_count;
        end
    end

    gcc_adj_matrix u_matrix (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .rd_row  (rd_row)
    );

    gcc_seq u_seq (
        .clk               (clk),
        .rst_n             (rst_n),
        .node_count_cfg    (node_count_reg),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .opcode            (opcode),
        .node_a            (node_a),
        .node_b            (node_b),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .component_index   (component_index),
        .member_node       (member_node),
        .last_in_component (last_in_component),
        .last              (last),
        .cmd               (cmd),
        .rd_addr           (rd_addr),
        .rd_row            (rd_row)
    );

    a_resolve_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (opcode == gcc_pkg::OP_RESOLVE)) |=> in_stall)
        else $error("resolve word did not make the block busy");

    a_last_ends_component: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> last_in_component)
        else $error("final word does not close its component");

    a_busy_after_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=> in_stall)
        else $error("block idle before the final word was emitted");

    a_busy_mid_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> in_stall)
        else $error("input taken while a resolve is still emitting");

endmodule
